/* rtl/rfa_pkg.sv */
// Shared types, constants and helpers for the register-file ALU.
// No dependencies; used by rfa_alu and register_file_alu_with_flags_unit.
package rfa_pkg;

  // register file geometry
  localparam int REG_COUNT = 8;
  localparam int DATA_WIDTH = 32;
  localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // number of conditional subtractions needed to fold a 3-bit index
  localparam int IDX_FOLD = 7 / REG_COUNT;

  // instruction codes
  localparam logic [2:0] CMD_MOV = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_AND = 3'd3;
  localparam logic [2:0] CMD_ORR = 3'd4;
  localparam logic [2:0] CMD_XOR = 3'd5;
  localparam logic [2:0] CMD_LSR = 3'd6;
  localparam logic [2:0] CMD_LSL = 3'd7;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // condition flags
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  // wrap a 3-bit register index into the implemented register count
  function automatic reg_idx_t reg_index(input logic [2:0] idx);
    logic [4:0] val;
    val = {2'b00, idx};
    for (int i = 0; i < IDX_FOLD; i++) begin
      if (val >= 5'(REG_COUNT)) begin
        val = val - 5'(REG_COUNT);
      end
    end
    return reg_idx_t'(val);
  endfunction

endpackage

/* rtl/register_file_alu_with_flags_unit.sv */
// Register-file ALU with NZCV flags: one decoded instruction per beat on eight
// 32-bit registers held in two mirrored synchronous RAMs (one per source
// operand), read at acceptance and written back as the item leaves execute.
// A new item can be accepted every cycle while the output is not blocked;
// the write-back of one instruction is forwarded to the next, so back-to-back
// dependent instructions run at full rate. Registers and flags read as zero
// after reset; per-register valid bits stand in for a clearing pass, so the
// block takes items right after reset. The result beat carries the written
// value, its register index and the flags afterwards.
// Depends on rfa_pkg, rfa_ram and rfa_alu.
module register_file_alu_with_flags_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic        in_set_flags,
  input  logic [2:0]  in_dest_reg,
  input  logic [2:0]  in_src_a_reg,
  input  logic [2:0]  in_src_b_reg,
  input  logic [31:0] in_immediate,
  input  logic [4:0]  in_shift_amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_value,
  output logic [2:0]  out_written_reg,
  output logic        out_flag_n,
  output logic        out_flag_z,
  output logic        out_flag_c,
  output logic        out_flag_v
);

  localparam int RC = rfa_pkg::REG_COUNT;

  // handshake
  logic              in_acc;
  logic              s1_adv;
  logic              s1_valid_r;
  logic              out_valid_r;

  // execute stage instruction
  logic [2:0]        s1_cmd_r;
  logic              s1_set_flags_r;
  rfa_pkg::reg_idx_t s1_dest_r;
  rfa_pkg::data_t    s1_imm_r;
  logic [4:0]        s1_shamt_r;

  // operand read and bypass
  rfa_pkg::reg_idx_t a_idx;
  rfa_pkg::reg_idx_t b_idx;
  rfa_pkg::data_t    ram_a;
  rfa_pkg::data_t    ram_b;
  logic              a_vld_r;
  logic              b_vld_r;
  logic              a_fwd_r;
  logic              b_fwd_r;
  rfa_pkg::data_t    fwd_data_r;
  rfa_pkg::data_t    op_a;
  rfa_pkg::data_t    op_b;
  logic [RC-1:0]     vld_r;

  // write-back and flags
  logic              wr_en;
  rfa_pkg::data_t    alu_res;
  rfa_pkg::flags_t   flags_r;
  rfa_pkg::flags_t   flags_nxt;

  // output register
  logic [31:0]       out_value_r;
  logic [2:0]        out_reg_r;
  rfa_pkg::flags_t   out_flags_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = s1_adv;
  assign a_idx    = rfa_pkg::reg_index(in_src_a_reg);
  assign b_idx    = rfa_pkg::reg_index(in_src_b_reg);

  // mirrored register file, one copy per read operand
  rfa_ram #(
    .WIDTH (rfa_pkg::DATA_WIDTH),
    .DEPTH (RC)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_dest_r),
    .wdata (alu_res),
    .re    (in_acc),
    .raddr (a_idx),
    .rdata (ram_a)
  );

  rfa_ram #(
    .WIDTH (rfa_pkg::DATA_WIDTH),
    .DEPTH (RC)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_dest_r),
    .wdata (alu_res),
    .re    (in_acc),
    .raddr (b_idx),
    .rdata (ram_b)
  );

  // stage valid, per-entry valid bits and bypass flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      vld_r      <= '0;
      a_vld_r    <= 1'b0;
      b_vld_r    <= 1'b0;
      a_fwd_r    <= 1'b0;
      b_fwd_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[s1_dest_r] <= 1'b1;
      end
      if (in_acc) begin
        a_vld_r <= vld_r[a_idx];
        b_vld_r <= vld_r[b_idx];
        a_fwd_r <= wr_en && (s1_dest_r == a_idx);
        b_fwd_r <= wr_en && (s1_dest_r == b_idx);
      end
    end
  end

  // instruction fields and bypass data for the execute stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r       <= in_cmd;
      s1_set_flags_r <= in_set_flags;
      s1_dest_r      <= rfa_pkg::reg_index(in_dest_reg);
      s1_imm_r       <= rfa_pkg::data_t'(in_immediate);
      s1_shamt_r     <= in_shift_amount;
      fwd_data_r     <= alu_res;
    end
  end

  // operand select: bypass, then stored value, else reset value
  assign op_a = a_fwd_r ? fwd_data_r : (a_vld_r ? ram_a : '0);
  assign op_b = b_fwd_r ? fwd_data_r : (b_vld_r ? ram_b : '0);

  rfa_alu u_alu (
    .cmd       (s1_cmd_r),
    .set_flags (s1_set_flags_r),
    .op_a      (op_a),
    .op_b      (op_b),
    .imm       (s1_imm_r),
    .shamt     (s1_shamt_r),
    .flags_in  (flags_r),
    .result    (alu_res),
    .flags_out (flags_nxt)
  );

  // flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r <= 32'(alu_res);
      out_reg_r   <= 3'(s1_dest_r);
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_written_reg  = out_reg_r;
  assign out_flag_n       = out_flags_r.n;
  assign out_flag_z       = out_flags_r.z;
  assign out_flag_c       = out_flags_r.c;
  assign out_flag_v       = out_flags_r.v;

  // the input stalls only when execute is full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked output");

  // a written register is valid from then on
  a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(s1_dest_r)])
    else $error("valid bit not set after write-back");

  // non-s forms leave the flags alone
  a_flags_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_set_flags_r) |=> (flags_r == $past(flags_r)))
    else $error("flags changed on a non-s instruction");

  // result beat carries the instruction just executed and the new flags
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_flags_r == flags_r
                && out_reg_r == 3'($past(s1_dest_r))))
    else $error("output register not loaded from execute stage");

  // a read that overlaps a write-back to the same entry takes the bypass
  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wr_en && s1_dest_r == a_idx) |=> a_fwd_r)
    else $error("missed operand bypass");

endmodule

/* rtl/rfa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents when read and write hit the same address.
// No dependencies.
module rfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rfa_alu.sv */
// Combinational execute unit: computes the result and the next NZCV flags.
// Depends on rfa_pkg.
module rfa_alu (
  input  logic [2:0]        cmd,
  input  logic              set_flags,
  input  rfa_pkg::data_t    op_a,
  input  rfa_pkg::data_t    op_b,
  input  rfa_pkg::data_t    imm,
  input  logic [4:0]        shamt,
  input  rfa_pkg::flags_t   flags_in,
  output rfa_pkg::data_t    result,
  output rfa_pkg::flags_t   flags_out
);

  localparam int DW = rfa_pkg::DATA_WIDTH;

  logic [DW:0]     sum;
  logic [DW:0]     diff;
  logic [DW:0]     shl_ext;
  logic [DW:0]     shr_ext;
  rfa_pkg::data_t  res;
  logic            c_bit;
  logic            v_bit;

  // adder, subtractor and shifters with one extra bit for the carry
  assign sum     = {1'b0, op_a} + {1'b0, op_b};
  assign diff    = {1'b0, op_a} - {1'b0, op_b};
  assign shl_ext = {1'b0, op_a} << shamt;
  assign shr_ext = {op_a, 1'b0} >> shamt;

  // operation select; logical ops keep c and v
  always_comb begin
    res   = '0;
    c_bit = flags_in.c;
    v_bit = flags_in.v;
    case (cmd)
      rfa_pkg::CMD_MOV: res = imm;
      rfa_pkg::CMD_ADD: begin
        res   = sum[DW-1:0];
        c_bit = sum[DW];
        v_bit = (op_a[DW-1] ^ res[DW-1]) & (op_b[DW-1] ^ res[DW-1]);
      end
      rfa_pkg::CMD_SUB: begin
        res   = diff[DW-1:0];
        c_bit = ~diff[DW];
        v_bit = (op_a[DW-1] ^ op_b[DW-1]) & (op_a[DW-1] ^ res[DW-1]);
      end
      rfa_pkg::CMD_AND: res = op_a & op_b;
      rfa_pkg::CMD_ORR: res = op_a | op_b;
      rfa_pkg::CMD_XOR: res = op_a ^ op_b;
      rfa_pkg::CMD_LSR: begin
        res = op_a >> shamt;
        if (shamt != 5'd0) begin
          c_bit = shr_ext[0];
        end
      end
      rfa_pkg::CMD_LSL: begin
        res = op_a << shamt;
        if (shamt != 5'd0) begin
          c_bit = shl_ext[DW];
        end
      end
      default: res = '0;
    endcase
  end

  // flags update only on the s form
  always_comb begin
    result = res;
    if (set_flags) begin
      flags_out.n = res[DW-1];
      flags_out.z = (res == '0);
      flags_out.c = c_bit;
      flags_out.v = v_bit;
    end else begin
      flags_out = flags_in;
    end
  end

endmodule

/* verif/tb_top.sv */
// Self-checking bench for register_file_alu_with_flags_unit: random and corner
// instructions checked against an in-bench model of the registers and NZCV flags.
// Depends on rfa_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int DW = rfa_pkg::DATA_WIDTH;
  localparam int RC = rfa_pkg::REG_COUNT;

  // one decoded instruction; hold_for_drain makes the sender wait for an empty pipe
  typedef struct {
    logic [2:0]  cmd;
    logic        set_flags;
    logic [2:0]  dest;
    logic [2:0]  src_a;
    logic [2:0]  src_b;
    logic [31:0] imm;
    logic [4:0]  shamt;
    logic        hold_for_drain;
  } instr_t;

  // one write-back beat
  typedef struct {
    rfa_pkg::data_t  value;
    logic [2:0]      wreg;
    rfa_pkg::flags_t flags;
  } writeback_t;

  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_CADENCE} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_cmd = rfa_pkg::CMD_MOV;
  logic        in_set_flags = 1'b0;
  logic [2:0]  in_dest_reg = 3'd0;
  logic [2:0]  in_src_a_reg = 3'd0;
  logic [2:0]  in_src_b_reg = 3'd0;
  logic [31:0] in_immediate = 32'd0;
  logic [4:0]  in_shift_amount = 5'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_value;
  logic [2:0]  out_written_reg;
  logic        out_flag_n;
  logic        out_flag_z;
  logic        out_flag_c;
  logic        out_flag_v;

  register_file_alu_with_flags_unit dut (.*);

  always #5 clk = ~clk;

  // architectural state as the bench sees it
  rfa_pkg::data_t  arch_regs [RC];
  rfa_pkg::flags_t arch_flags;
  instr_t          instr_queue[$];
  writeback_t      expected_writebacks[$];
  int              errors = 0;

  // sender state
  instr_t cur_instr;
  int     burst_left = 0;
  int     gap_left = 0;
  int     n_issued = 0;
  int     n_retired = 0;

  // receiver state
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          mode_left = 0;
  int          rx_cycle = 0;
  writeback_t  want;

  function automatic int wrap_idx(input logic [2:0] idx);
    return int'(idx) % RC;
  endfunction

  // execute one instruction on the bench state and return its write-back
  function automatic writeback_t execute_instr(input instr_t ins);
    rfa_pkg::data_t a;
    rfa_pkg::data_t b;
    rfa_pkg::data_t r;
    logic [DW:0]    sum;
    logic           c;
    logic           v;
    int             d;
    writeback_t     wb;
    a = arch_regs[wrap_idx(ins.src_a)];
    b = arch_regs[wrap_idx(ins.src_b)];
    d = wrap_idx(ins.dest);
    c = arch_flags.c;
    v = arch_flags.v;
    r = '0;
    case (ins.cmd)
      rfa_pkg::CMD_MOV: r = rfa_pkg::data_t'(ins.imm);
      rfa_pkg::CMD_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        r = sum[DW-1:0];
        c = sum[DW];
        v = (a[DW-1] == b[DW-1]) && (r[DW-1] != a[DW-1]);
      end
      rfa_pkg::CMD_SUB: begin
        r = a - b;
        c = (a >= b);
        v = (a[DW-1] != b[DW-1]) && (r[DW-1] != a[DW-1]);
      end
      rfa_pkg::CMD_AND: r = a & b;
      rfa_pkg::CMD_ORR: r = a | b;
      rfa_pkg::CMD_XOR: r = a ^ b;
      rfa_pkg::CMD_LSR: begin
        r = a;
        if (ins.shamt != 0) begin
          r = a >> ins.shamt;
          c = a[int'(ins.shamt) - 1];
        end
      end
      rfa_pkg::CMD_LSL: begin
        r = a;
        if (ins.shamt != 0) begin
          r = a << ins.shamt;
          c = a[DW - int'(ins.shamt)];
        end
      end
      default: r = '0;
    endcase
    arch_regs[d] = r;
    if (ins.set_flags) begin
      arch_flags.n = r[DW-1];
      arch_flags.z = (r == '0);
      arch_flags.c = c;
      arch_flags.v = v;
    end
    wb.value = r;
    wb.wreg = 3'(d);
    wb.flags = arch_flags;
    return wb;
  endfunction

  function automatic instr_t mk(input logic [2:0] cmd, input logic s, input logic [2:0] d,
                                input logic [2:0] a, input logic [2:0] b,
                                input logic [31:0] imm, input logic [4:0] sh);
    instr_t t;
    t.cmd = cmd;
    t.set_flags = s;
    t.dest = d;
    t.src_a = a;
    t.src_b = b;
    t.imm = imm;
    t.shamt = sh;
    t.hold_for_drain = 1'b0;
    return t;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // sender: bursts and gaps, payload held until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        expected_writebacks.push_back(execute_instr(cur_instr));
        n_issued++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (instr_queue.size() == 0 || (instr_queue[0].hold_for_drain &&
                   (n_issued - n_retired - ((out_valid && out_ready) ? 1 : 0)) != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur_instr = instr_queue.pop_front();
        in_valid <= 1'b1;
        in_cmd <= cur_instr.cmd;
        in_set_flags <= cur_instr.set_flags;
        in_dest_reg <= cur_instr.dest;
        in_src_a_reg <= cur_instr.src_a;
        in_src_b_reg <= cur_instr.src_b;
        in_immediate <= cur_instr.imm;
        in_shift_amount <= cur_instr.shamt;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
        end
      end
    end
  end

  // receiver: check each beat, then pick the next ready value
  always @(posedge clk) begin
    rx_cycle++;
    if (rst_n && out_valid && out_ready) begin
      n_retired <= n_retired + 1;
      if (expected_writebacks.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual value %h reg %0d", $time,
                 out_result_value, out_written_reg);
        errors++;
      end else begin
        want = expected_writebacks.pop_front();
        check_field("result_value", want.value, out_result_value);
        check_field("written_reg", 32'(want.wreg), 32'(out_written_reg));
        check_field("flag_n", 32'(want.flags.n), 32'(out_flag_n));
        check_field("flag_z", 32'(want.flags.z), 32'(out_flag_z));
        check_field("flag_c", 32'(want.flags.c), 32'(out_flag_c));
        check_field("flag_v", 32'(want.flags.v), 32'(out_flag_v));
      end
    end
    if (mode_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS:  out_ready <= 1'b1;
      RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
      RDY_CADENCE: out_ready <= (rx_cycle % 3 != 0);
      default:     out_ready <= 1'b1;
    endcase
  end

  // stimulus, reset and end of run
  initial begin
    rfa_pkg::data_t corner_vals [5];
    instr_t         t;
    corner_vals = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    for (int i = 0; i < RC; i++) arch_regs[i] = '0;
    arch_flags = '0;

    // directed: corner values, carry, overflow, zero, shift edges
    instr_queue.push_back(mk(rfa_pkg::CMD_ADD, 1'b1, 3'd7, 3'd0, 3'd1, 32'h0, 5'd0));  // zeros
    instr_queue.push_back(mk(rfa_pkg::CMD_MOV, 1'b1, 3'd0, 3'd0, 3'd0, 32'hFFFF_FFFF, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_MOV, 1'b1, 3'd1, 3'd0, 3'd0, 32'h0, 5'd31));
    instr_queue.push_back(mk(rfa_pkg::CMD_MOV, 1'b0, 3'd2, 3'd7, 3'd7, 32'h7FFF_FFFF, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_MOV, 1'b0, 3'd3, 3'd0, 3'd0, 32'h8000_0000, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_MOV, 1'b0, 3'd4, 3'd0, 3'd0, 32'h1, 5'd0));
    // signed overflow, then carry and zero
    instr_queue.push_back(mk(rfa_pkg::CMD_ADD, 1'b1, 3'd5, 3'd2, 3'd4, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_ADD, 1'b1, 3'd6, 3'd0, 3'd4, 32'h0, 5'd0));
    // movs keeps c and v
    instr_queue.push_back(mk(rfa_pkg::CMD_MOV, 1'b1, 3'd7, 3'd0, 3'd0, 32'h8000_0000, 5'd0));
    // borrow, overflow, then zero with no borrow
    instr_queue.push_back(mk(rfa_pkg::CMD_SUB, 1'b1, 3'd5, 3'd1, 3'd4, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_SUB, 1'b1, 3'd6, 3'd3, 3'd4, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_SUB, 1'b1, 3'd7, 3'd4, 3'd4, 32'h0, 5'd0));
    // flags untouched
    instr_queue.push_back(mk(rfa_pkg::CMD_ADD, 1'b0, 3'd5, 3'd0, 3'd0, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_AND, 1'b1, 3'd6, 3'd0, 3'd3, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_ORR, 1'b1, 3'd7, 3'd2, 3'd3, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_XOR, 1'b1, 3'd6, 3'd0, 3'd0, 32'h0, 5'd0));
    // shift by zero, then shift edges
    instr_queue.push_back(mk(rfa_pkg::CMD_LSR, 1'b1, 3'd5, 3'd0, 3'd0, 32'h0, 5'd0));
    instr_queue.push_back(mk(rfa_pkg::CMD_LSR, 1'b1, 3'd5, 3'd4, 3'd0, 32'h0, 5'd1));
    instr_queue.push_back(mk(rfa_pkg::CMD_LSR, 1'b1, 3'd6, 3'd0, 3'd0, 32'h0, 5'd31));
    // carry out, then dest is source
    instr_queue.push_back(mk(rfa_pkg::CMD_LSL, 1'b1, 3'd7, 3'd3, 3'd0, 32'h0, 5'd1));
    instr_queue.push_back(mk(rfa_pkg::CMD_LSL, 1'b1, 3'd0, 3'd0, 3'd0, 32'h0, 5'd31));
    instr_queue.push_back(mk(rfa_pkg::CMD_LSL, 1'b0, 3'd1, 3'd2, 3'd0, 32'h0, 5'd0));
    t = mk(rfa_pkg::CMD_ADD, 1'b1, 3'd2, 3'd0, 3'd2, 32'h0, 5'd0);
    t.hold_for_drain = 1'b1;
    instr_queue.push_back(t);

    // random: three tenths are loads of corner or random values, shifts lean to the edges
    for (int i = 0; i < 1530; i++) begin
      t.cmd = ($urandom_range(0, 4) == 0) ? rfa_pkg::CMD_MOV : 3'($urandom_range(0, 7));
      t.set_flags = 1'($urandom_range(0, 1));
      t.dest = 3'($urandom_range(0, 7));
      t.src_a = 3'($urandom_range(0, 7));
      t.src_b = 3'($urandom_range(0, 7));
      t.imm = ($urandom_range(0, 2) == 0) ? corner_vals[$urandom_range(0, 4)] : $urandom;
      case ($urandom_range(0, 5))
        0: t.shamt = 5'd0;
        1: t.shamt = 5'd1;
        2: t.shamt = 5'd31;
        default: t.shamt = 5'($urandom_range(0, 31));
      endcase
      t.hold_for_drain = (i % 400 == 399);
      instr_queue.push_back(t);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (instr_queue.size() != 0 || in_valid || expected_writebacks.size() != 0);
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
